>>> design/ecg_sample_recorder_stats_core_defines.svh
// assertion macros used by the ecg recorder back end
// expects signals named clock and reset in the asserting module
`ifndef ECG_SAMPLE_RECORDER_STATS_CORE_DEFINES_SVH
`define ECG_SAMPLE_RECORDER_STATS_CORE_DEFINES_SVH

// same-cycle implication
`define ECGREC_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ECGREC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/ecgrec_pkg.sv
// types and constants for the ecg sample recorder
// used by every module of the block; no dependencies
`timescale 1ns / 1ps

package ecgrec_pkg;

   // operation codes of a request
   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_START  = 2'd1,
      OP_STOP   = 2'd2
   } op_type;

   // status codes of a response
   typedef enum logic [1:0] {
      ST_STORED   = 2'd0,
      ST_IGNORED  = 2'd1,
      ST_OUTSIDE  = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   // register indexes of the csr port
   localparam int unsigned CsrIndexWidth = 3;
   localparam logic [CsrIndexWidth-1:0] CSR_WINDOW_MS    = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_CAPACITY     = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_CLIP_LOW     = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_CLIP_HIGH    = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_ECG_ENABLED  = 3'd4;

   // reset values of the registers
   localparam logic [31:0] WindowMsReset  = 32'd10000;
   localparam logic [16:0] CapacityReset  = 17'd11000;
   localparam logic [11:0] ClipLowReset   = 12'd0;
   localparam logic [11:0] ClipHighReset  = 12'd4095;

   // divide by 1000: q = (x * DivMagic) >> DivShift, exact for 32-bit x
   localparam logic [28:0] DivMagic   = 29'h10624DD3;
   localparam int unsigned ProdWidth  = 61;
   localparam int unsigned DivShift   = 38;
   localparam int unsigned QuotWidth  = ProdWidth - DivShift;
   localparam logic [31:0] UsPerMs    = 32'd1000;

   // request queue between front and back
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueuePtrW  = 2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [11:0] sample_value;
      logic [31:0] taken_us;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] slot_index;
      logic [31:0] stamp_ms;
      logic [11:0] value_out;
      logic [16:0] stored_count;
      logic [31:0] first_time_us;
      logic [31:0] last_time_us;
      logic [31:0] min_period_us;
      logic [31:0] max_period_us;
      logic [16:0] clip_low_total;
      logic [16:0] clip_high_total;
      logic        overflow_flag;
   } rsp_type;

   // classified request as handed from front to back
   typedef struct packed {
      logic [1:0]  operation;
      logic [11:0] sample_value;
      logic [31:0] taken_us;
      logic [31:0] quot_ms;
      logic [31:0] quot_inc_ms;
      logic [31:0] quot_inc_us;
   } item_type;

   // configuration seen by the back end
   typedef struct packed {
      logic [31:0] window_ms;
      logic [16:0] capacity;
      logic [11:0] clip_low_level;
      logic [11:0] clip_high_level;
      logic        ecg_enabled;
   } cfg_type;

endpackage

>>> design/ecgrec_front.sv
// front end: two-stage pipeline that derives the millisecond stamp
// depends on ecgrec_pkg
`timescale 1ns / 1ps

module ecgrec_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ecgrec_pkg::req_type  req_data,
   output logic                 item_valid,
   input  logic                 item_ready,
   output ecgrec_pkg::item_type item_data
);

   logic                                 s1_valid_ff, s1_valid_in;
   ecgrec_pkg::req_type                  s1_req_ff;
   logic [ecgrec_pkg::ProdWidth-1:0]     s1_prod_ff, s1_prod_in;
   logic                                 s2_valid_ff, s2_valid_in;
   ecgrec_pkg::item_type                 s2_item_ff, s2_item_in;
   logic                                 s2_move, s1_take;
   logic [31:0]                          quot, quot_inc;

   // stage handshakes
   assign s2_move   = !s2_valid_ff || item_ready;
   assign req_ready = !s1_valid_ff || s2_move;
   assign s1_take   = s1_valid_ff && s2_move;

   // stage 1: reciprocal multiply
   assign s1_prod_in  = req_data.taken_us * ecgrec_pkg::DivMagic;
   assign s1_valid_in = (req_valid && req_ready) ? 1'b1 : (s2_move ? 1'b0 : s1_valid_ff);

   // stage 2: quotient, next stamp and its microsecond time
   always_comb begin
      quot     = {{(32 - ecgrec_pkg::QuotWidth){1'b0}},
                  s1_prod_ff[ecgrec_pkg::ProdWidth-1:ecgrec_pkg::DivShift]};
      quot_inc = quot + 32'd1;
      s2_item_in.operation    = s1_req_ff.operation;
      s2_item_in.sample_value = s1_req_ff.sample_value;
      s2_item_in.taken_us     = s1_req_ff.taken_us;
      s2_item_in.quot_ms      = quot;
      s2_item_in.quot_inc_ms  = quot_inc;
      // times 1000 as 1024 - 32 + 8
      s2_item_in.quot_inc_us  = (quot_inc << 10) - (quot_inc << 5) + (quot_inc << 3);
   end
   assign s2_valid_in = s1_take ? 1'b1 : (item_ready ? 1'b0 : s2_valid_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_req_ff  <= req_data;
         s1_prod_ff <= s1_prod_in;
      end
      if (s1_take) begin
         s2_item_ff <= s2_item_in;
      end
   end

   assign item_valid = s2_valid_ff;
   assign item_data  = s2_item_ff;

endmodule

>>> design/ecgrec_queue.sv
// small request queue between front and back ends
// depends on ecgrec_pkg
`timescale 1ns / 1ps

module ecgrec_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  ecgrec_pkg::item_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output ecgrec_pkg::item_type out_data
);

   ecgrec_pkg::item_type                entry_ff [ecgrec_pkg::QueueDepth];
   logic [ecgrec_pkg::QueuePtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [ecgrec_pkg::QueuePtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [ecgrec_pkg::QueuePtrW:0]      count_ff, count_in;
   logic                                push, pop;

   // full check does not look at the pop side
   assign in_ready  = count_ff != (ecgrec_pkg::QueuePtrW + 1)'(ecgrec_pkg::QueueDepth);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = entry_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

>>> design/ecgrec_back.sv
// back end: measurement state, statistics and response register
// depends on ecgrec_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "ecg_sample_recorder_stats_core_defines.svh"

module ecgrec_back (
   input  logic                 clock,
   input  logic                 reset,
   input  ecgrec_pkg::cfg_type  cfg,
   input  logic                 item_valid,
   output logic                 item_ready,
   input  ecgrec_pkg::item_type item_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ecgrec_pkg::rsp_type  rsp_data
);

   logic                armed_ff, armed_in;
   logic [31:0]         prev_stamp_ff, prev_stamp_in;
   logic [31:0]         stamp_inc_ff, stamp_inc_in;
   logic [31:0]         next_us_ff, next_us_in;
   logic [16:0]         sample_total_ff, sample_total_in;
   logic [31:0]         first_us_ff, first_us_in;
   logic [31:0]         last_us_ff, last_us_in;
   logic [31:0]         shortest_gap_ff, shortest_gap_in;
   logic [31:0]         longest_gap_ff, longest_gap_in;
   logic [16:0]         low_clips_ff, low_clips_in;
   logic [16:0]         high_clips_ff, high_clips_in;
   logic                overflowed_ff, overflowed_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ecgrec_pkg::rsp_type rsp_ff, rsp_in;

   logic                pop, forced, store;
   logic [31:0]         stamp, time_us, gap;

   assign pop        = item_valid && (!rsp_valid_ff || rsp_ready);
   assign item_ready = !rsp_valid_ff || rsp_ready;

   // stamp forcing and gap
   always_comb begin
      forced  = (sample_total_ff != 17'd0) && (item_data.quot_ms <= prev_stamp_ff);
      stamp   = forced ? stamp_inc_ff : item_data.quot_ms;
      time_us = forced ? next_us_ff : item_data.taken_us;
      gap     = time_us - last_us_ff;
   end

   // request execution
   always_comb begin
      armed_in        = armed_ff;
      prev_stamp_in   = prev_stamp_ff;
      stamp_inc_in    = stamp_inc_ff;
      next_us_in      = next_us_ff;
      sample_total_in = sample_total_ff;
      first_us_in     = first_us_ff;
      last_us_in      = last_us_ff;
      shortest_gap_in = shortest_gap_ff;
      longest_gap_in  = longest_gap_ff;
      low_clips_in    = low_clips_ff;
      high_clips_in   = high_clips_ff;
      overflowed_in   = overflowed_ff;
      store           = 1'b0;

      rsp_in.status     = ecgrec_pkg::ST_IGNORED;
      rsp_in.slot_index = '0;
      rsp_in.stamp_ms   = '0;
      rsp_in.value_out  = '0;

      if (pop) begin
         case (item_data.operation)
            ecgrec_pkg::OP_START: begin
               if (!armed_ff) begin
                  armed_in        = 1'b1;
                  prev_stamp_in   = '0;
                  stamp_inc_in    = 32'd1;
                  next_us_in      = ecgrec_pkg::UsPerMs;
                  sample_total_in = '0;
                  first_us_in     = '0;
                  last_us_in      = '0;
                  shortest_gap_in = '1;
                  longest_gap_in  = '0;
                  low_clips_in    = '0;
                  high_clips_in   = '0;
                  overflowed_in   = 1'b0;
               end
            end
            ecgrec_pkg::OP_STOP: begin
               armed_in = 1'b0;
            end
            ecgrec_pkg::OP_SAMPLE: begin
               if (armed_ff && cfg.ecg_enabled) begin
                  rsp_in.stamp_ms = stamp;
                  if (stamp < cfg.window_ms) begin
                     if (sample_total_ff < cfg.capacity) begin
                        store = 1'b1;
                        if (sample_total_ff == 17'd0) begin
                           first_us_in = time_us;
                        end else begin
                           if (gap < shortest_gap_ff) begin
                              shortest_gap_in = gap;
                           end
                           if (gap > longest_gap_ff) begin
                              longest_gap_in = gap;
                           end
                        end
                        last_us_in = time_us;
                        if (item_data.sample_value <= cfg.clip_low_level) begin
                           low_clips_in = low_clips_ff + 17'd1;
                        end
                        if (item_data.sample_value >= cfg.clip_high_level) begin
                           high_clips_in = high_clips_ff + 17'd1;
                        end
                        prev_stamp_in     = stamp;
                        stamp_inc_in      = forced ? stamp_inc_ff + 32'd1
                                                   : item_data.quot_inc_ms;
                        next_us_in        = forced ? next_us_ff + ecgrec_pkg::UsPerMs
                                                   : item_data.quot_inc_us;
                        sample_total_in   = sample_total_ff + 17'd1;
                        rsp_in.status     = ecgrec_pkg::ST_STORED;
                        rsp_in.slot_index = sample_total_ff[15:0];
                        rsp_in.value_out  = item_data.sample_value;
                     end else begin
                        overflowed_in = 1'b1;
                        rsp_in.status = ecgrec_pkg::ST_OVERFLOW;
                     end
                  end else begin
                     rsp_in.status = ecgrec_pkg::ST_OUTSIDE;
                  end
               end
            end
            default: begin
               armed_in = armed_ff;
            end
         endcase
      end

      // statistics after this request
      rsp_in.stored_count    = sample_total_in;
      rsp_in.first_time_us   = first_us_in;
      rsp_in.last_time_us    = last_us_in;
      rsp_in.min_period_us   = shortest_gap_in;
      rsp_in.max_period_us   = longest_gap_in;
      rsp_in.clip_low_total  = low_clips_in;
      rsp_in.clip_high_total = high_clips_in;
      rsp_in.overflow_flag   = overflowed_in;

      rsp_valid_in = pop ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff        <= 1'b0;
         prev_stamp_ff   <= '0;
         stamp_inc_ff    <= 32'd1;
         next_us_ff      <= ecgrec_pkg::UsPerMs;
         sample_total_ff <= '0;
         first_us_ff     <= '0;
         last_us_ff      <= '0;
         shortest_gap_ff <= '1;
         longest_gap_ff  <= '0;
         low_clips_ff    <= '0;
         high_clips_ff   <= '0;
         overflowed_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         armed_ff        <= armed_in;
         prev_stamp_ff   <= prev_stamp_in;
         stamp_inc_ff    <= stamp_inc_in;
         next_us_ff      <= next_us_in;
         sample_total_ff <= sample_total_in;
         first_us_ff     <= first_us_in;
         last_us_ff      <= last_us_in;
         shortest_gap_ff <= shortest_gap_in;
         longest_gap_ff  <= longest_gap_in;
         low_clips_ff    <= low_clips_in;
         high_clips_ff   <= high_clips_in;
         overflowed_ff   <= overflowed_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `ECGREC_ASSERT_IMPLY(a_pop_needs_slot, pop, (!rsp_valid_ff || rsp_ready), "request taken while response stalled")
   `ECGREC_ASSERT_IMPLY(a_gap_order, (sample_total_ff > 17'd1), (shortest_gap_ff <= longest_gap_ff), "min period above max period")
   `ECGREC_ASSERT_IMPLY(a_stamp_inc, (sample_total_ff != 17'd0), (stamp_inc_ff == prev_stamp_ff + 32'd1), "stamp increment out of step")
   `ECGREC_ASSERT_NEXT(a_overflow_sticky, (overflowed_ff && !(pop && item_data.operation == ecgrec_pkg::OP_START)), overflowed_ff, "overflow flag lost")
   `ECGREC_ASSERT_NEXT(a_slot_is_count, store, (rsp_ff.slot_index == sample_total_ff[15:0] - 16'd1), "slot index out of step with count")

endmodule

>>> design/ecg_sample_recorder_stats_core.sv
// Timed ECG sample recorder: one request in and one response out per clock at full rate. A
// request passes a two-stage front end (the millisecond stamp is formed by a pipelined
// reciprocal multiply), a four-entry queue and a back end that updates the measurement
// statistics and loads the response register; each of these is registered in turn. Throughput,
// one request per cycle while responses are taken, is set by the back end's statistics update;
// either side may stall without stopping the other while the queue has room.
// Top level: configuration registers, input masking and the front, queue and back ends.
// Depends on ecgrec_pkg, ecgrec_front, ecgrec_queue and ecgrec_back.
`timescale 1ns / 1ps

module ecg_sample_recorder_stats_core #(
   parameter int unsigned DEPTH       = 65536,
   parameter int unsigned SAMPLE_BITS = 12
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  ecgrec_pkg::req_type                    req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output ecgrec_pkg::rsp_type                    rsp_data,
   input  logic                                   csr_wen,
   input  logic [ecgrec_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [31:0]                            csr_wdata
);

   localparam logic [11:0] SampleMask = (SAMPLE_BITS >= 12) ? 12'hFFF
                                        : 12'((1 << SAMPLE_BITS) - 1);
   localparam logic [31:0] DepthLimit = 32'(DEPTH);

   ecgrec_pkg::cfg_type  cfg_ff, cfg_in;
   ecgrec_pkg::req_type  req_masked;
   ecgrec_pkg::item_type front_item, back_item;
   logic                 front_valid, front_ready, back_valid, back_ready;

   // csr writes, capacity clamped to the DEPTH parameter
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            ecgrec_pkg::CSR_WINDOW_MS: begin
               cfg_in.window_ms = csr_wdata;
            end
            ecgrec_pkg::CSR_CAPACITY: begin
               cfg_in.capacity = ({15'b0, csr_wdata[16:0]} > DepthLimit) ? 17'(DEPTH)
                                                                         : csr_wdata[16:0];
            end
            ecgrec_pkg::CSR_CLIP_LOW: begin
               cfg_in.clip_low_level = csr_wdata[11:0];
            end
            ecgrec_pkg::CSR_CLIP_HIGH: begin
               cfg_in.clip_high_level = csr_wdata[11:0];
            end
            ecgrec_pkg::CSR_ECG_ENABLED: begin
               cfg_in.ecg_enabled = csr_wdata[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_ms       <= ecgrec_pkg::WindowMsReset;
         cfg_ff.capacity        <= ({15'b0, ecgrec_pkg::CapacityReset} > DepthLimit)
                                   ? 17'(DEPTH) : ecgrec_pkg::CapacityReset;
         cfg_ff.clip_low_level  <= ecgrec_pkg::ClipLowReset;
         cfg_ff.clip_high_level <= ecgrec_pkg::ClipHighReset;
         cfg_ff.ecg_enabled     <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sample value kept to its converter width
   always_comb begin
      req_masked              = req_data;
      req_masked.sample_value = req_data.sample_value & SampleMask;
   end

   ecgrec_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_masked),
      .item_valid (front_valid),
      .item_ready (front_ready),
      .item_data  (front_item)
   );

   ecgrec_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_item),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_data  (back_item)
   );

   ecgrec_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (back_valid),
      .item_ready (back_ready),
      .item_data  (back_item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

>>> dv/ecg_sample_recorder_stats_core_tb.sv
// testbench for ecg_sample_recorder_stats_core: directed and random requests
// checked against an in-bench predictor of the recorder statistics
// depends on ecgrec_pkg and the recorder rtl
`timescale 1ns / 1ps

module ecg_sample_recorder_stats_core_tb;

   // code with no operation assigned, must be ignored
   localparam logic [1:0] OpUnused = 2'd3;
   localparam int unsigned UsableSlots = 65536;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   ecgrec_pkg::req_type                  req_data = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   ecgrec_pkg::rsp_type                  rsp_data;
   logic                                 csr_wen = 1'b0;
   logic [ecgrec_pkg::CsrIndexWidth-1:0] csr_index = '0;
   logic [31:0]                          csr_wdata = '0;

   ecg_sample_recorder_stats_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor copy of the registers
   logic [31:0] cfg_window;
   logic [16:0] cfg_capacity;
   logic [11:0] cfg_clip_low;
   logic [11:0] cfg_clip_high;
   logic        cfg_ecg_on;

   // predictor copy of the measurement state
   logic        running;
   logic [31:0] last_stamp;
   logic [16:0] n_stored;
   logic [31:0] t_first;
   logic [31:0] t_last;
   logic [31:0] gap_min;
   logic [31:0] gap_max;
   logic [16:0] n_clip_low;
   logic [16:0] n_clip_high;
   logic        overflow_seen;

   ecgrec_pkg::rsp_type awaited_records[$];
   ecgrec_pkg::rsp_type want_rsp;
   int      errors = 0;
   int      sent_count = 0;
   bit      steady = 1'b0;

   function automatic void clear_statistics();
      last_stamp    = '0;
      n_stored      = '0;
      t_first       = '0;
      t_last        = '0;
      gap_min       = '1;
      gap_max       = '0;
      n_clip_low    = '0;
      n_clip_high   = '0;
      overflow_seen = 1'b0;
   endfunction

   function automatic void reset_recorder_model();
      cfg_window    = ecgrec_pkg::WindowMsReset;
      cfg_capacity  = ecgrec_pkg::CapacityReset;
      cfg_clip_low  = ecgrec_pkg::ClipLowReset;
      cfg_clip_high = ecgrec_pkg::ClipHighReset;
      cfg_ecg_on    = 1'b1;
      running       = 1'b0;
      clear_statistics();
   endfunction

   // one request through the recorder: updates state, returns the response
   function automatic ecgrec_pkg::rsp_type record_request(ecgrec_pkg::req_type r);
      ecgrec_pkg::rsp_type o;
      logic [31:0] us;
      logic [31:0] stamp;
      logic [31:0] gap;
      logic [16:0] slots;
      o = '0;
      o.status = ecgrec_pkg::ST_IGNORED;
      us = r.taken_us;
      case (r.operation)
         ecgrec_pkg::OP_START: begin
            if (!running) begin
               clear_statistics();
               running = 1'b1;
            end
         end
         ecgrec_pkg::OP_STOP: running = 1'b0;
         ecgrec_pkg::OP_SAMPLE: begin
            if (running && cfg_ecg_on) begin
               slots = (cfg_capacity > UsableSlots) ? 17'(UsableSlots) : cfg_capacity;
               stamp = us / 32'd1000;
               // stamps must rise strictly; push forward and rebuild the time
               if (n_stored != 0 && stamp <= last_stamp) begin
                  stamp = last_stamp + 32'd1;
                  us = stamp * 32'd1000;
               end
               o.stamp_ms = stamp;
               if (stamp < cfg_window) begin
                  if (n_stored < slots) begin
                     if (n_stored == 0) begin
                        t_first = us;
                     end else begin
                        gap = us - t_last;
                        if (gap < gap_min) gap_min = gap;
                        if (gap > gap_max) gap_max = gap;
                     end
                     t_last = us;
                     if (r.sample_value <= cfg_clip_low) n_clip_low++;
                     if (r.sample_value >= cfg_clip_high) n_clip_high++;
                     o.slot_index = n_stored[15:0];
                     o.value_out  = r.sample_value;
                     last_stamp   = stamp;
                     n_stored++;
                     o.status = ecgrec_pkg::ST_STORED;
                  end else begin
                     overflow_seen = 1'b1;
                     o.status = ecgrec_pkg::ST_OVERFLOW;
                  end
               end else begin
                  o.status = ecgrec_pkg::ST_OUTSIDE;
               end
            end
         end
         default: ;
      endcase
      o.stored_count    = n_stored;
      o.first_time_us   = t_first;
      o.last_time_us    = t_last;
      o.min_period_us   = gap_min;
      o.max_period_us   = gap_max;
      o.clip_low_total  = n_clip_low;
      o.clip_high_total = n_clip_high;
      o.overflow_flag   = overflow_seen;
      return o;
   endfunction

   function automatic ecgrec_pkg::req_type make_req(logic [1:0] op, logic [11:0] value,
                                                    logic [31:0] us);
      ecgrec_pkg::req_type r;
      r.operation    = op;
      r.sample_value = value;
      r.taken_us     = us;
      return r;
   endfunction

   // sample values lean on the extremes and the clip levels
   function automatic logic [11:0] pick_value();
      case ($urandom_range(7))
         0: return 12'h000;
         1: return 12'hFFF;
         2: return cfg_clip_low;
         3: return cfg_clip_high;
         default: return 12'($urandom);
      endcase
   endfunction

   // send one request, optionally after an idle gap; returns at the accepting edge
   task automatic send_request(ecgrec_pkg::req_type r);
      ecgrec_pkg::rsp_type predicted;
      if (!steady && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      predicted = record_request(r);
      awaited_records.push_back(predicted);
      sent_count++;
   endtask

   // stop sending and let every outstanding response come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (awaited_records.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // register write; only called while the recorder is idle
   task automatic write_register(logic [ecgrec_pkg::CsrIndexWidth-1:0] idx,
                                 logic [31:0] value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (idx)
         ecgrec_pkg::CSR_WINDOW_MS:   cfg_window    = value;
         ecgrec_pkg::CSR_CAPACITY:    cfg_capacity  = value[16:0];
         ecgrec_pkg::CSR_CLIP_LOW:    cfg_clip_low  = value[11:0];
         ecgrec_pkg::CSR_CLIP_HIGH:   cfg_clip_high = value[11:0];
         ecgrec_pkg::CSR_ECG_ENABLED: cfg_ecg_on    = value[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // response stall pattern
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 30);
   end

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         errors++;
      end
   endtask

   // compare each response with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_records.size() == 0) begin
            $display("%0t: response with none awaited, expected nothing, actual %p",
                     $time, rsp_data);
            errors++;
         end else begin
            want_rsp = awaited_records.pop_front();
            check_field("status", want_rsp.status, rsp_data.status);
            check_field("slot_index", want_rsp.slot_index, rsp_data.slot_index);
            check_field("stamp_ms", want_rsp.stamp_ms, rsp_data.stamp_ms);
            check_field("value_out", want_rsp.value_out, rsp_data.value_out);
            check_field("stored_count", want_rsp.stored_count, rsp_data.stored_count);
            check_field("first_time_us", want_rsp.first_time_us, rsp_data.first_time_us);
            check_field("last_time_us", want_rsp.last_time_us, rsp_data.last_time_us);
            check_field("min_period_us", want_rsp.min_period_us, rsp_data.min_period_us);
            check_field("max_period_us", want_rsp.max_period_us, rsp_data.max_period_us);
            check_field("clip_low_total", want_rsp.clip_low_total,
                        rsp_data.clip_low_total);
            check_field("clip_high_total", want_rsp.clip_high_total,
                        rsp_data.clip_high_total);
            check_field("overflow_flag", want_rsp.overflow_flag, rsp_data.overflow_flag);
         end
      end
   end

   // start, stop, unknown code and samples while disarmed and armed
   task automatic test_control_requests();
      send_request(make_req(ecgrec_pkg::OP_SAMPLE, 12'hFFF, 32'd1234));
      send_request(make_req(OpUnused, 12'h000, 32'hFFFF_FFFF));
      send_request(make_req(ecgrec_pkg::OP_STOP, 12'h123, 32'd0));
      send_request(make_req(ecgrec_pkg::OP_START, 12'h000, 32'd0));
      send_request(make_req(ecgrec_pkg::OP_SAMPLE, 12'h000, 32'd0));
      // start while armed keeps the statistics
      send_request(make_req(ecgrec_pkg::OP_START, 12'hFFF, 32'd77));
      send_request(make_req(ecgrec_pkg::OP_STOP, 12'h000, 32'd0));
      send_request(make_req(ecgrec_pkg::OP_SAMPLE, 12'h456, 32'd5000));
   endtask

   // repeated and backward stamps, extreme values, stamp past the window
   task automatic test_sample_extremes();
      send_request(make_req(ecgrec_pkg::OP_START, 12'h000, 32'd0));
      send_request(make_req(ecgrec_pkg::OP_SAMPLE, 12'hFFF, 32'd1500));
      send_request(make_req(ecgrec_pkg::OP_SAMPLE, 12'hAAA, 32'd1999));
      send_request(make_req(ecgrec_pkg::OP_SAMPLE, 12'h555, 32'd700));
      send_request(make_req(ecgrec_pkg::OP_SAMPLE, 12'h800, 32'd9_999_999));
      send_request(make_req(ecgrec_pkg::OP_SAMPLE, 12'h7FF, 32'hFFFF_FFFF));
      send_request(make_req(ecgrec_pkg::OP_STOP, 12'h000, 32'd0));
   endtask

   // tiny window and capacity: overflow, outside window, zero capacity, capture off
   task automatic test_window_and_capacity();
      wait_drained();
      write_register(ecgrec_pkg::CSR_WINDOW_MS, 32'd3);
      write_register(ecgrec_pkg::CSR_CAPACITY, 32'd2);
      send_request(make_req(ecgrec_pkg::OP_START, 12'h000, 32'd0));
      send_request(make_req(ecgrec_pkg::OP_SAMPLE, 12'h010, 32'd0));
      send_request(make_req(ecgrec_pkg::OP_SAMPLE, 12'h020, 32'd1000));
      send_request(make_req(ecgrec_pkg::OP_SAMPLE, 12'h030, 32'd2000));
      send_request(make_req(ecgrec_pkg::OP_SAMPLE, 12'h040, 32'd5000));
      send_request(make_req(ecgrec_pkg::OP_STOP, 12'h000, 32'd0));
      wait_drained();
      write_register(ecgrec_pkg::CSR_CAPACITY, 32'd0);
      write_register(ecgrec_pkg::CSR_ECG_ENABLED, 32'd0);
      send_request(make_req(ecgrec_pkg::OP_START, 12'h000, 32'd0));
      send_request(make_req(ecgrec_pkg::OP_SAMPLE, 12'h100, 32'd0));
      wait_drained();
      write_register(ecgrec_pkg::CSR_ECG_ENABLED, 32'd1);
      send_request(make_req(ecgrec_pkg::OP_SAMPLE, 12'h100, 32'd0));
      send_request(make_req(ecgrec_pkg::OP_STOP, 12'h000, 32'd0));
   endtask

   // new random settings, extremes included
   task automatic reconfigure_random();
      wait_drained();
      case ($urandom_range(5))
         0: write_register(ecgrec_pkg::CSR_WINDOW_MS, 32'd0);
         1: write_register(ecgrec_pkg::CSR_WINDOW_MS, 32'hFFFF_FFFF);
         2: write_register(ecgrec_pkg::CSR_WINDOW_MS, $urandom_range(1, 50));
         default: write_register(ecgrec_pkg::CSR_WINDOW_MS, $urandom_range(20, 3000));
      endcase
      case ($urandom_range(7))
         0: write_register(ecgrec_pkg::CSR_CAPACITY, 32'd0);
         1: write_register(ecgrec_pkg::CSR_CAPACITY, 32'd131071);
         2: write_register(ecgrec_pkg::CSR_CAPACITY, 32'd65536);
         3: write_register(ecgrec_pkg::CSR_CAPACITY, 32'd65537);
         default: write_register(ecgrec_pkg::CSR_CAPACITY, $urandom_range(1, 60));
      endcase
      case ($urandom_range(3))
         0: write_register(ecgrec_pkg::CSR_CLIP_LOW, 32'd0);
         1: write_register(ecgrec_pkg::CSR_CLIP_LOW, 32'd4095);
         default: write_register(ecgrec_pkg::CSR_CLIP_LOW, $urandom_range(0, 600));
      endcase
      case ($urandom_range(3))
         0: write_register(ecgrec_pkg::CSR_CLIP_HIGH, 32'd0);
         1: write_register(ecgrec_pkg::CSR_CLIP_HIGH, 32'd4095);
         default: write_register(ecgrec_pkg::CSR_CLIP_HIGH, $urandom_range(3500, 4095));
      endcase
      write_register(ecgrec_pkg::CSR_ECG_ENABLED, ($urandom_range(9) != 0) ? 32'd1 : 32'd0);
   endtask

   // one measurement: start, a run of timed samples, stop, either end sometimes left out, with some noise mixed in
   task automatic run_measurement();
      logic [31:0] t;
      int          n;
      t = ($urandom_range(9) == 0) ? 32'($urandom) : 32'($urandom_range(0, 5000));
      n = $urandom_range(1, 40);
      if ($urandom_range(9) != 0) begin
         send_request(make_req(ecgrec_pkg::OP_START, 12'($urandom), $urandom));
      end
      repeat (n) begin
         if ($urandom_range(99) < 12) begin
            send_request(make_req(2'($urandom_range(0, 3)), 12'($urandom), $urandom));
         end else begin
            case ($urandom_range(9))
               0, 1, 2, 3: t = t + $urandom_range(0, 999);
               4, 5, 6, 7: t = t + $urandom_range(1000, 20000);
               8: t = t - $urandom_range(0, 3000);
               default: t = $urandom;
            endcase
            send_request(make_req(ecgrec_pkg::OP_SAMPLE, pick_value(), t));
         end
      end
      if ($urandom_range(9) != 0) begin
         send_request(make_req(ecgrec_pkg::OP_STOP, 12'($urandom), $urandom));
      end
   endtask

   task automatic test_random_measurements();
      int target;
      int steady_from;
      target = sent_count + 1925;
      steady_from = sent_count + $urandom_range(400, 1200);
      while (sent_count < target) begin
         if ($urandom_range(3) == 0) reconfigure_random();
         // one stretch with no idling on either side
         steady = (sent_count >= steady_from) && (sent_count < steady_from + 250);
         run_measurement();
      end
      steady = 1'b0;
   endtask

   // test sequence
   initial begin
      reset_recorder_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_control_requests();
      test_sample_extremes();
      test_window_and_capacity();
      test_random_measurements();
      wait_drained();
      if (errors == 0 && awaited_records.size() == 0) begin
         $display("** ecg_sample_recorder_stats_core: PASSED **");
      end else begin
         $display("** ecg_sample_recorder_stats_core: FAILED **");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("** ecg_sample_recorder_stats_core: FAILED **");
      $finish;
   end

endmodule

>>> files.f
+incdir+design
design/ecgrec_pkg.sv
design/ecgrec_front.sv
design/ecgrec_queue.sv
design/ecgrec_back.sv
design/ecg_sample_recorder_stats_core.sv
dv/ecg_sample_recorder_stats_core_tb.sv
